FILE: rtl/ptpg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pedal torque plausibility gate: shared package
// Widths, register indexes and the structs that pass between the
// configuration bank, the shared divider and the sequencer.
// ----------------------------------------------------------------------------
package ptpg_pkg;

    // Field widths.
    localparam int CODE_W     = 12;
    localparam int PCT_W      = 7;
    localparam int CMD_W      = 15;
    localparam int TIME_W     = 32;
    localparam int TIMEOUT_W  = 16;
    localparam int FAULT_W    = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Shared divider: dividend is a code times one hundred, divisor a code span.
    localparam int DIVIDEND_W = 19;
    localparam int DIVISOR_W  = CODE_W;
    localparam int STEP_CNT_W = $clog2(DIVIDEND_W + 1);

    localparam logic [PCT_W-1:0]      PCT_FULL   = 7'd100;
    localparam logic [DIVIDEND_W-1:0] PCT_SCALE  = 19'd100;
    localparam int                    CMD_FRAC_W = 8;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ACCEL_DEADBAND  = 3'd0,
        CFG_ADC_FULL_SCALE  = 3'd1,
        CFG_BRAKE_ACTIVE    = 3'd2,
        CFG_TRIP_PCT        = 3'd3,
        CFG_CLEAR_PCT       = 3'd4,
        CFG_LINK_TIMEOUT    = 3'd5,
        CFG_MAX_RISE        = 3'd6,
        CFG_BRAKE_LIGHT     = 3'd7
    } cfg_idx_t;

    // Current configuration as seen by the datapath.
    typedef struct packed {
        logic [CODE_W-1:0]    accel_deadband;
        logic [CODE_W-1:0]    adc_full_scale;
        logic [PCT_W-1:0]     brake_active_pct;
        logic [PCT_W-1:0]     trip_pct;
        logic [PCT_W-1:0]     clear_pct;
        logic [TIMEOUT_W-1:0] link_timeout_ms;
        logic [CMD_W-1:0]     max_rise;
        logic [PCT_W-1:0]     brake_light_pct;
    } cfg_t;

    // Divider request and response.
    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic                  done;
        logic [DIVIDEND_W-1:0] quotient;
    } div_rsp_t;

endpackage

FILE: rtl/ptpg_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pedal torque plausibility gate: configuration bank
// Holds the eight configuration registers and takes one write per cycle.
// ----------------------------------------------------------------------------
module ptpg_cfg (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             wr_en,
    input  logic [ptpg_pkg::CFG_IDX_W-1:0]   wr_index,
    input  logic [ptpg_pkg::CFG_DATA_W-1:0]  wr_data,
    output ptpg_pkg::cfg_t                   cfg
);

    ptpg_pkg::cfg_t cfg_reg;
    ptpg_pkg::cfg_t cfg_next;

    // Decode the register index and replace the selected field.
    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (ptpg_pkg::cfg_idx_t'(wr_index))
                ptpg_pkg::CFG_ACCEL_DEADBAND:
                    cfg_next.accel_deadband = wr_data[ptpg_pkg::CODE_W-1:0];
                ptpg_pkg::CFG_ADC_FULL_SCALE:
                    cfg_next.adc_full_scale = wr_data[ptpg_pkg::CODE_W-1:0];
                ptpg_pkg::CFG_BRAKE_ACTIVE:
                    cfg_next.brake_active_pct = wr_data[ptpg_pkg::PCT_W-1:0];
                ptpg_pkg::CFG_TRIP_PCT:
                    cfg_next.trip_pct = wr_data[ptpg_pkg::PCT_W-1:0];
                ptpg_pkg::CFG_CLEAR_PCT:
                    cfg_next.clear_pct = wr_data[ptpg_pkg::PCT_W-1:0];
                ptpg_pkg::CFG_LINK_TIMEOUT:
                    cfg_next.link_timeout_ms = wr_data[ptpg_pkg::TIMEOUT_W-1:0];
                ptpg_pkg::CFG_MAX_RISE:
                    cfg_next.max_rise = wr_data[ptpg_pkg::CMD_W-1:0];
                ptpg_pkg::CFG_BRAKE_LIGHT:
                    cfg_next.brake_light_pct = wr_data[ptpg_pkg::PCT_W-1:0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.accel_deadband   <= 12'd100;
            cfg_reg.adc_full_scale   <= 12'd4095;
            cfg_reg.brake_active_pct <= 7'd10;
            cfg_reg.trip_pct         <= 7'd25;
            cfg_reg.clear_pct        <= 7'd5;
            cfg_reg.link_timeout_ms  <= 16'd100;
            cfg_reg.max_rise         <= 15'd256;
            cfg_reg.brake_light_pct  <= 7'd10;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: rtl/ptpg_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pedal torque plausibility gate: shared divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ptpg_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  ptpg_pkg::div_req_t req,
    output ptpg_pkg::div_rsp_t rsp
);

    localparam int DVD_W = ptpg_pkg::DIVIDEND_W;
    localparam int DVS_W = ptpg_pkg::DIVISOR_W;
    localparam int CNT_W = ptpg_pkg::STEP_CNT_W;

    logic [DVD_W-1:0] quo_reg, quo_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [DVS_W:0]   trial;
    logic [DVS_W+1:0] diff;

    // One restoring step: shift in the next dividend bit and try a subtract.
    always_comb begin
        trial     = {rem_reg, quo_reg[DVD_W-1]};
        diff      = {1'b0, trial} - {2'b00, dvs_reg};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
            cnt_next  = CNT_W'(DVD_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!diff[DVS_W+1]) begin
                rem_next = diff[DVS_W-1:0];
                quo_next = {quo_reg[DVD_W-2:0], 1'b1};
            end else begin
                rem_next = trial[DVS_W-1:0];
                quo_next = {quo_reg[DVD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

FILE: rtl/pedal_torque_plausibility_gate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pedal torque plausibility gate: top level
// Maps pedal codes to percent, runs the plausibility latch, the inverter
// watchdog and the rising slew limit on the torque command.
// ----------------------------------------------------------------------------
// The shared divider produces one quotient bit per cycle and is run twice,
// once for the accelerator and once for the brake. Each run consists of a
// start state, 19 bit steps and a registered done flag. The ST_DONE state
// then forms the result. While a sample is in progress s_tready is low. It
// returns high together with m_tvalid, so a new sample is not accepted until
// the result of the last one has been formed. A finished result waits in the
// output register, and the next sample may be accepted while it waits. If a
// result is still waiting when the following one is ready, ST_DONE is held
// until the output register is free.
// Configuration writes are taken every cycle and must only be issued while the
// block is idle.
// ----------------------------------------------------------------------------
module pedal_torque_plausibility_gate (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Input sample.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // accel_code[11:0], brake_code[23:12], now_ms[55:24], heard_ms[87:56],
    // fault_code[95:88]
    input  logic [95:0]                     s_tdata,
    // Result.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // pedal_pct[6:0], brake_pct[13:7], plaus_cut[14], link_stale[15],
    // inv_fault[16], torque_cmd[31:17], brake_on[32], zero fill[39:33]
    output logic [39:0]                     m_tdata,
    // Configuration writes.
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ptpg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ptpg_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int CODE_W  = ptpg_pkg::CODE_W;
    localparam int PCT_W   = ptpg_pkg::PCT_W;
    localparam int CMD_W   = ptpg_pkg::CMD_W;
    localparam int TIME_W  = ptpg_pkg::TIME_W;
    localparam int FAULT_W = ptpg_pkg::FAULT_W;
    localparam int DVD_W   = ptpg_pkg::DIVIDEND_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACC_GO,
        ST_ACC_WAIT,
        ST_BRK_GO,
        ST_BRK_WAIT,
        ST_DONE
    } state_t;

    ptpg_pkg::cfg_t     cfg;
    ptpg_pkg::div_req_t div_req;
    ptpg_pkg::div_rsp_t div_rsp;

    // Sequencer, captured sample and results.
    state_t              state_reg, state_next;
    logic [CODE_W-1:0]   accel_reg, accel_next;
    logic [CODE_W-1:0]   brake_reg, brake_next;
    logic [TIME_W-1:0]   now_reg, now_next;
    logic [TIME_W-1:0]   heard_reg, heard_next;
    logic [FAULT_W-1:0]  fault_reg, fault_next;
    logic                pedal_zero_reg, pedal_zero_next;
    logic                stale_reg, stale_next;
    logic [PCT_W-1:0]    pedal_reg, pedal_next;
    logic                latch_reg, latch_next;
    logic [CMD_W-1:0]    prev_cmd_reg, prev_cmd_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [39:0]         m_tdata_reg, m_tdata_next;

    logic                s_accept;
    logic                out_free;
    logic [CODE_W-1:0]   accel_span;
    logic [CODE_W-1:0]   accel_off;
    logic [TIME_W-1:0]   elapsed;
    logic [PCT_W-1:0]    quo_pct;
    logic [PCT_W-1:0]    brake_pct;
    logic                latch_upd;
    logic                cut;
    logic [CMD_W-1:0]    target;
    logic [CMD_W-1:0]    rise;
    logic [CMD_W-1:0]    cmd;

    ptpg_cfg u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    ptpg_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;

    // Accelerator span and offset above the deadband.
    assign accel_span = cfg.adc_full_scale - cfg.accel_deadband;
    assign accel_off  = accel_reg - cfg.accel_deadband;
    assign elapsed    = now_reg - heard_reg;

    // Quotient clamped to full scale.
    assign quo_pct = (div_rsp.quotient > DVD_W'(ptpg_pkg::PCT_FULL)) ?
                     ptpg_pkg::PCT_FULL : div_rsp.quotient[PCT_W-1:0];
    assign brake_pct = (cfg.adc_full_scale == '0) ? '0 : quo_pct;

    // Plausibility latch: clear below the clear level wins over a trip.
    always_comb begin
        latch_upd = latch_reg;
        if (brake_pct > cfg.brake_active_pct && pedal_reg > cfg.trip_pct) begin
            latch_upd = 1'b1;
        end
        if (pedal_reg < cfg.clear_pct) begin
            latch_upd = 1'b0;
        end
    end

    // Rising slew limit; falls pass through at once.
    assign cut    = latch_upd || stale_reg || (fault_reg != '0);
    assign target = cut ? '0 : {pedal_reg, {ptpg_pkg::CMD_FRAC_W{1'b0}}};
    assign rise   = target - prev_cmd_reg;
    assign cmd    = (target > prev_cmd_reg && rise > cfg.max_rise) ?
                    (prev_cmd_reg + cfg.max_rise) : target;

    // Sequencer next state and divider requests.
    always_comb begin
        state_next       = state_reg;
        accel_next       = accel_reg;
        brake_next       = brake_reg;
        now_next         = now_reg;
        heard_next       = heard_reg;
        fault_next       = fault_reg;
        pedal_zero_next  = pedal_zero_reg;
        stale_next       = stale_reg;
        pedal_next       = pedal_reg;
        latch_next       = latch_reg;
        prev_cmd_next    = prev_cmd_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        m_tdata_next     = m_tdata_reg;
        div_req.start    = 1'b0;
        div_req.dividend = DVD_W'(accel_off) * ptpg_pkg::PCT_SCALE;
        div_req.divisor  = accel_span;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    accel_next = s_tdata[11:0];
                    brake_next = s_tdata[23:12];
                    now_next   = s_tdata[55:24];
                    heard_next = s_tdata[87:56];
                    fault_next = s_tdata[95:88];
                    state_next = ST_ACC_GO;
                end
            end
            ST_ACC_GO: begin
                div_req.start   = 1'b1;
                pedal_zero_next = (accel_reg <= cfg.accel_deadband) ||
                                  (cfg.adc_full_scale <= cfg.accel_deadband);
                stale_next      = (heard_reg == '0) ||
                                  (elapsed > TIME_W'(cfg.link_timeout_ms));
                state_next      = ST_ACC_WAIT;
            end
            ST_ACC_WAIT: begin
                if (div_rsp.done) begin
                    pedal_next = pedal_zero_reg ? '0 : quo_pct;
                    state_next = ST_BRK_GO;
                end
            end
            ST_BRK_GO: begin
                div_req.start    = 1'b1;
                div_req.dividend = DVD_W'(brake_reg) * ptpg_pkg::PCT_SCALE;
                div_req.divisor  = cfg.adc_full_scale;
                state_next       = ST_BRK_WAIT;
            end
            ST_BRK_WAIT: begin
                if (div_rsp.done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                // The brake quotient stays in the divider until used here.
                if (out_free) begin
                    latch_next    = latch_upd;
                    prev_cmd_next = cmd;
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {7'd0,
                                     (brake_pct > cfg.brake_light_pct),
                                     cmd,
                                     (fault_reg != '0),
                                     stale_reg,
                                     latch_upd,
                                     brake_pct,
                                     pedal_reg};
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            latch_reg    <= 1'b0;
            prev_cmd_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            latch_reg    <= latch_next;
            prev_cmd_reg <= prev_cmd_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        accel_reg      <= accel_next;
        brake_reg      <= brake_next;
        now_reg        <= now_next;
        heard_reg      <= heard_next;
        fault_reg      <= fault_next;
        pedal_zero_reg <= pedal_zero_next;
        stale_reg      <= stale_next;
        pedal_reg      <= pedal_next;
        m_tdata_reg    <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef ASSERT_OFF
    // A cut, stale link or fault forces the command to zero at once.
    a_cut_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[14] || m_tdata[15] || m_tdata[16]))
            |-> (m_tdata[31:17] == '0))
        else $error("torque command not zero while cut");

    // The command never exceeds full pedal.
    a_cmd_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[31:17] <= 15'd25600))
        else $error("torque command out of range");

    // Both percentages are clamped to full scale.
    a_pct_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[6:0] <= ptpg_pkg::PCT_FULL &&
                      m_tdata[13:7] <= ptpg_pkg::PCT_FULL))
        else $error("percentage out of range");

    // An accepted request keeps the block busy on the next cycle.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("ready stayed high after accept");
`endif

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pedal torque plausibility gate: self-checking testbench
// Sends pedal samples through the stream input under several register
// settings. Each sample's result is predicted from a local copy of the
// registers, the plausibility latch and the last command. Every result is
// compared field by field, in order, with its prediction.
// ----------------------------------------------------------------------------
module testbench;

    localparam int CODE_W     = ptpg_pkg::CODE_W;
    localparam int PCT_W      = ptpg_pkg::PCT_W;
    localparam int CMD_W      = ptpg_pkg::CMD_W;
    localparam int TIME_W     = ptpg_pkg::TIME_W;
    localparam int TIMEOUT_W  = ptpg_pkg::TIMEOUT_W;
    localparam int FAULT_W    = ptpg_pkg::FAULT_W;
    localparam int CFG_IDX_W  = ptpg_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = ptpg_pkg::CFG_DATA_W;

    // Input sample as packed on s_tdata, with accel_code in the lowest bits.
    typedef struct packed {
        logic [FAULT_W-1:0] fault_code;
        logic [TIME_W-1:0]  heard_ms;
        logic [TIME_W-1:0]  now_ms;
        logic [CODE_W-1:0]  brake_code;
        logic [CODE_W-1:0]  accel_code;
    } pedal_sample_t;

    // Result as packed on m_tdata, with pedal_pct in the lowest bits.
    typedef struct packed {
        logic [6:0]       fill;
        logic             brake_on;
        logic [CMD_W-1:0] torque_cmd;
        logic             inv_fault;
        logic             link_stale;
        logic             plaus_cut;
        logic [PCT_W-1:0] brake_pct;
        logic [PCT_W-1:0] pedal_pct;
    } gate_result_t;

    // Predicts each result and checks the results in order.
    class torque_gate_scoreboard;
        ptpg_pkg::cfg_t   regs;
        bit               cut_latched;
        logic [CMD_W-1:0] prev_torque;
        gate_result_t     awaited_results[$];
        int unsigned      mismatches;
        int unsigned      results_checked;
        int unsigned      cuts_seen;
        int unsigned      stale_seen;
        int unsigned      faults_seen;
        int unsigned      lights_seen;
        int unsigned      full_cmd_seen;

        function new();
            regs.accel_deadband   = 12'd100;
            regs.adc_full_scale   = 12'd4095;
            regs.brake_active_pct = 7'd10;
            regs.trip_pct         = 7'd25;
            regs.clear_pct        = 7'd5;
            regs.link_timeout_ms  = 16'd100;
            regs.max_rise         = 15'd256;
            regs.brake_light_pct  = 7'd10;
            cut_latched = 1'b0;
            prev_torque = '0;
        endfunction

        function void write_reg(ptpg_pkg::cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                ptpg_pkg::CFG_ACCEL_DEADBAND: regs.accel_deadband = value[CODE_W-1:0];
                ptpg_pkg::CFG_ADC_FULL_SCALE: regs.adc_full_scale = value[CODE_W-1:0];
                ptpg_pkg::CFG_BRAKE_ACTIVE:   regs.brake_active_pct = value[PCT_W-1:0];
                ptpg_pkg::CFG_TRIP_PCT:       regs.trip_pct = value[PCT_W-1:0];
                ptpg_pkg::CFG_CLEAR_PCT:      regs.clear_pct = value[PCT_W-1:0];
                ptpg_pkg::CFG_LINK_TIMEOUT:   regs.link_timeout_ms = value[TIMEOUT_W-1:0];
                ptpg_pkg::CFG_MAX_RISE:       regs.max_rise = value[CMD_W-1:0];
                ptpg_pkg::CFG_BRAKE_LIGHT:    regs.brake_light_pct = value[PCT_W-1:0];
                default: ;
            endcase
        endfunction

        // Works out one result and advances the latch and the command.
        function gate_result_t predict_gate(pedal_sample_t s);
            gate_result_t      r;
            longint            span;
            longint            quot;
            longint            rise;
            longint            target;
            int unsigned       pedal;
            int unsigned       bpct;
            logic [TIME_W-1:0] elapsed;
            bit                stale;
            bit                flt;

            // Accelerator: deadband, then truncating scale over the span.
            pedal = 0;
            span = longint'(regs.adc_full_scale) - longint'(regs.accel_deadband);
            if (s.accel_code > regs.accel_deadband && span > 0) begin
                quot = (longint'(s.accel_code) - longint'(regs.accel_deadband)) * 100
                       / span;
                pedal = (quot > 100) ? 100 : int'(quot);
            end

            // Brake: scale over the full range; a zero full scale reads zero.
            bpct = 0;
            if (regs.adc_full_scale != 0) begin
                quot = longint'(s.brake_code) * 100 / longint'(regs.adc_full_scale);
                bpct = (quot > 100) ? 100 : int'(quot);
            end

            // The clear condition is applied last, so it wins over a trip.
            if (bpct > regs.brake_active_pct && pedal > regs.trip_pct)
                cut_latched = 1'b1;
            if (pedal < regs.clear_pct)
                cut_latched = 1'b0;

            elapsed = s.now_ms - s.heard_ms;
            stale = (s.heard_ms == 0) || (elapsed > TIME_W'(regs.link_timeout_ms));
            flt = (s.fault_code != 0);

            // Rising slew only; falls pass at once.
            target = (cut_latched || stale || flt) ? 0 : longint'(pedal) * 256;
            rise = target - longint'(prev_torque);
            if (rise > longint'(regs.max_rise))
                rise = longint'(regs.max_rise);
            prev_torque = CMD_W'(longint'(prev_torque) + rise);

            r.fill       = '0;
            r.pedal_pct  = PCT_W'(pedal);
            r.brake_pct  = PCT_W'(bpct);
            r.plaus_cut  = cut_latched;
            r.link_stale = stale;
            r.inv_fault  = flt;
            r.torque_cmd = prev_torque;
            r.brake_on   = (bpct > regs.brake_light_pct);
            return r;
        endfunction

        function void note_sample(pedal_sample_t s);
            awaited_results.push_back(predict_gate(s));
        endfunction

        function int unsigned pending();
            return awaited_results.size();
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            if (mismatches <= 40)
                $display("[%0t] mismatch: %s", $realtime, msg);
        endtask

        task compare_field(string name, int unsigned got, int unsigned want);
            if (got != want)
                report_mismatch($sformatf("result %0d %s is %0d, predicted %0d",
                                          results_checked, name, got, want));
        endtask

        task check_result(gate_result_t got);
            gate_result_t want;
            if (awaited_results.size() == 0) begin
                report_mismatch($sformatf("result 0x%010h with no sample outstanding",
                                          got));
                return;
            end
            want = awaited_results.pop_front();
            compare_field("pedal_pct", got.pedal_pct, want.pedal_pct);
            compare_field("brake_pct", got.brake_pct, want.brake_pct);
            compare_field("plaus_cut", got.plaus_cut, want.plaus_cut);
            compare_field("link_stale", got.link_stale, want.link_stale);
            compare_field("inv_fault", got.inv_fault, want.inv_fault);
            compare_field("torque_cmd", got.torque_cmd, want.torque_cmd);
            compare_field("brake_on", got.brake_on, want.brake_on);
            compare_field("zero fill", got.fill, want.fill);
            results_checked++;
            cuts_seen     += want.plaus_cut;
            stale_seen    += want.link_stale;
            faults_seen   += want.inv_fault;
            lights_seen   += want.brake_on;
            full_cmd_seen += (want.torque_cmd == 25600);
        endtask
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [95:0]           s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [39:0]           m_tdata;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    torque_gate_scoreboard sb;
    pedal_sample_t         sample_q[$];
    ptpg_pkg::cfg_t        active_settings;
    logic [TIME_W-1:0]     clock_ms;
    int                    pedal_level;
    bit                    brake_pressed;
    int unsigned           settings_applied;
    int unsigned           stall_mode;
    int unsigned           stall_left;

    pedal_torque_plausibility_gate u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock.
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Safety net against a hung handshake.
    initial begin
        #8_000_000;
        $display("Run timed out with %0d results outstanding.", sb.pending());
        $display("FAIL");
        $finish;
    end

    // Result side: check each accepted result and stall on a pattern of
    // changing modes, from always ready to long stretches of refusal.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            stall_mode = 0;
            stall_left = 0;
        end else begin
            if (m_tvalid && m_tready)
                sb.check_result(gate_result_t'(m_tdata));
            if (stall_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                stall_left = $urandom_range(20, 300);
            end else begin
                stall_left--;
            end
            case (stall_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 1) == 0);
                2: m_tready <= ($urandom_range(0, 7) == 0);
                default: m_tready <= ((stall_left % 23) < 15);
            endcase
        end
    end

    function automatic int unsigned pick_value(int unsigned lo, int unsigned hi);
        int unsigned roll;
        roll = $urandom_range(0, 4);
        if (roll == 0)
            return lo;
        if (roll == 1)
            return hi;
        return $urandom_range(lo, hi);
    endfunction

    // Percent thresholds mostly stay in range; a few exceed 100.
    function automatic int unsigned pick_pct();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(101, 127);
        return pick_value(0, 100);
    endfunction

    function automatic ptpg_pkg::cfg_t random_settings();
        ptpg_pkg::cfg_t c;
        c.adc_full_scale = ($urandom_range(0, 11) == 0) ? '0 : CODE_W'(pick_value(1, 4095));
        if ($urandom_range(0, 5) == 0)
            c.accel_deadband = CODE_W'(pick_value(0, 4095));
        else
            c.accel_deadband = CODE_W'(pick_value(0, c.adc_full_scale / 2));
        c.brake_active_pct = PCT_W'(pick_pct());
        c.trip_pct         = PCT_W'(pick_pct());
        c.clear_pct        = PCT_W'(pick_pct());
        c.link_timeout_ms  = TIMEOUT_W'(pick_value(0, 65535));
        c.max_rise         = ($urandom_range(0, 5) == 0) ? CMD_W'(1) :
                             CMD_W'(pick_value(0, 25600));
        c.brake_light_pct  = PCT_W'(pick_pct());
        return c;
    endfunction

    // Mostly a plausible drive: time moving forward, a drifting pedal, the
    // brake pressed and released, and a live link. The rest is noise.
    function automatic pedal_sample_t random_sample();
        pedal_sample_t s;
        if ($urandom_range(0, 19) == 0) begin
            s = {$urandom, $urandom, $urandom};
            return s;
        end
        if ($urandom_range(0, 63) == 0)
            clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 200);
        else
            clock_ms = clock_ms + $urandom_range(1, 20);
        case ($urandom_range(0, 7))
            0: pedal_level = 0;
            1: pedal_level = int'($urandom_range(0, 4095));
            default: pedal_level = pedal_level + int'($urandom_range(0, 800)) - 400;
        endcase
        if (pedal_level < 0)
            pedal_level = 0;
        if (pedal_level > 4095)
            pedal_level = 4095;
        if ($urandom_range(0, 7) == 0)
            brake_pressed = !brake_pressed;
        s.accel_code = CODE_W'(pedal_level);
        s.brake_code = brake_pressed ? CODE_W'($urandom_range(300, 4095)) :
                                       CODE_W'($urandom_range(0, 250));
        s.now_ms = clock_ms;
        case ($urandom_range(0, 19))
            0: s.heard_ms = '0;
            1: s.heard_ms = $urandom;
            default: s.heard_ms = clock_ms -
                         $urandom_range(0, active_settings.link_timeout_ms + 3);
        endcase
        s.fault_code = ($urandom_range(0, 15) == 0) ? FAULT_W'($urandom_range(1, 255)) :
                                                      '0;
        return s;
    endfunction

    task automatic queue_sample(int unsigned accel, int unsigned brake,
                                logic [TIME_W-1:0] now, logic [TIME_W-1:0] heard,
                                int unsigned fault);
        pedal_sample_t s;
        s.accel_code = CODE_W'(accel);
        s.brake_code = CODE_W'(brake);
        s.now_ms     = now;
        s.heard_ms   = heard;
        s.fault_code = FAULT_W'(fault);
        sample_q.push_back(s);
    endtask

    // Writes all eight registers back to back; the block must be idle.
    task automatic apply_settings(ptpg_pkg::cfg_t c);
        logic [CFG_DATA_W-1:0] values [8];
        values[ptpg_pkg::CFG_ACCEL_DEADBAND] = CFG_DATA_W'(c.accel_deadband);
        values[ptpg_pkg::CFG_ADC_FULL_SCALE] = CFG_DATA_W'(c.adc_full_scale);
        values[ptpg_pkg::CFG_BRAKE_ACTIVE]   = CFG_DATA_W'(c.brake_active_pct);
        values[ptpg_pkg::CFG_TRIP_PCT]       = CFG_DATA_W'(c.trip_pct);
        values[ptpg_pkg::CFG_CLEAR_PCT]      = CFG_DATA_W'(c.clear_pct);
        values[ptpg_pkg::CFG_LINK_TIMEOUT]   = CFG_DATA_W'(c.link_timeout_ms);
        values[ptpg_pkg::CFG_MAX_RISE]       = CFG_DATA_W'(c.max_rise);
        values[ptpg_pkg::CFG_BRAKE_LIGHT]    = CFG_DATA_W'(c.brake_light_pct);
        for (int i = 0; i < 8; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= ptpg_pkg::cfg_idx_t'(i);
            cfg_data  <= values[i];
            do @(posedge aclk); while (!cfg_ready);
            sb.write_reg(ptpg_pkg::cfg_idx_t'(i), values[i]);
        end
        cfg_valid <= 1'b0;
        active_settings = c;
        settings_applied++;
    endtask

    // Sends every queued sample in bursts of random length with random gaps.
    task automatic send_samples();
        int unsigned burst_left;
        int unsigned gap;
        burst_left = 0;
        while (sample_q.size() > 0) begin
            if (burst_left == 0) begin
                burst_left = ($urandom_range(0, 5) == 0) ? 60 : $urandom_range(1, 16);
                gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
                if (gap > 0) begin
                    s_tvalid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
            s_tvalid <= 1'b1;
            s_tdata  <= sample_q[0];
            do @(posedge aclk); while (!s_tready);
            sb.note_sample(sample_q.pop_front());
            burst_left--;
        end
        s_tvalid <= 1'b0;
    endtask

    task automatic wait_until_drained();
        while (sb.pending() != 0)
            @(posedge aclk);
    endtask

    // Main sequence.
    initial begin
        ptpg_pkg::cfg_t c;
        sb = new();
        active_settings = sb.regs;
        clock_ms = 32'd5000;
        pedal_level = 0;
        brake_pressed = 1'b0;
        settings_applied = 0;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed samples under the reset settings.
        queue_sample(0, 0, 0, 0, 0);                          // never heard
        queue_sample(4095, 0, 1000, 990, 0);                  // full pedal, ramp starts
        queue_sample(4095, 0, 1001, 995, 0);
        queue_sample(4095, 0, 1002, 1000, 0);
        queue_sample(4095, 0, 1003, 1000, 0);
        queue_sample(100, 0, 1004, 1000, 0);                  // at deadband, instant fall
        queue_sample(101, 0, 1005, 1000, 0);                  // just above deadband
        queue_sample(4095, 4095, 1006, 1000, 0);              // brake with throttle trips
        queue_sample(2000, 0, 1007, 1000, 0);                 // latch holds without brake
        queue_sample(250, 0, 1008, 1000, 0);                  // low throttle clears
        queue_sample(4095, 0, 1101, 1001, 0);                 // elapsed equals timeout
        queue_sample(4095, 0, 1102, 1001, 0);                 // one past timeout
        queue_sample(4095, 0, 5, 32'hFFFF_FFF0, 0);           // time wraps, link live
        queue_sample(4095, 0, 6, 32'hFFFF_FFF0, 1);           // smallest fault code
        queue_sample(4095, 450, 7, 0, 8'hFF);                 // brake light just off
        queue_sample(4095, 451, 8, 1, 0);                     // brake light just on
        queue_sample(4095, 4095, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
        queue_sample(0, 4095, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        send_samples();
        wait_until_drained();

        // Low thresholds with clear at 100: the clear wins over a trip.
        c.accel_deadband = '0;      c.adc_full_scale = 12'd4095;
        c.brake_active_pct = '0;    c.trip_pct = '0;       c.clear_pct = 7'd100;
        c.link_timeout_ms = '0;     c.max_rise = '0;       c.brake_light_pct = '0;
        apply_settings(c);
        repeat (110) sample_q.push_back(random_sample());
        send_samples();
        wait_until_drained();

        // High extremes: zero accelerator span, widest timeout and rise.
        c.accel_deadband = 12'd4095;    c.adc_full_scale = 12'd4095;
        c.brake_active_pct = 7'd100;    c.trip_pct = 7'd100;      c.clear_pct = '0;
        c.link_timeout_ms = 16'd65535;  c.max_rise = 15'd25600;   c.brake_light_pct = 7'd100;
        apply_settings(c);
        repeat (110) sample_q.push_back(random_sample());
        send_samples();
        wait_until_drained();

        // Zero full scale, and thresholds beyond 100 that can never be met.
        c.accel_deadband = '0;       c.adc_full_scale = '0;
        c.brake_active_pct = 7'd127; c.trip_pct = 7'd127;       c.clear_pct = '0;
        c.link_timeout_ms = 16'd50;  c.max_rise = 15'd25600;    c.brake_light_pct = 7'd127;
        apply_settings(c);
        repeat (110) sample_q.push_back(random_sample());
        send_samples();
        wait_until_drained();

        // Random settings with the extremes favored.
        repeat (8) begin
            apply_settings(random_settings());
            repeat (110) sample_q.push_back(random_sample());
            send_samples();
            wait_until_drained();
        end

        // Let any stray result show up before the verdict.
        repeat (60) @(posedge aclk);
        $display("Checked %0d results over %0d register settings after the reset values.",
                 sb.results_checked, settings_applied);
        $display("Seen: %0d latch cuts, %0d stale links, %0d faults, %0d brake lights,",
                 sb.cuts_seen, sb.stale_seen, sb.faults_seen, sb.lights_seen);
        $display("and %0d full commands.", sb.full_cmd_seen);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
